/* rtl/sliding_median_filter_macros.svh */
// Assertion macros for the sliding median filter.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SLIDING_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define SMF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sliding_median_filter assertion failed");
// Check on every clock edge, reset included.
`define SMF_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sliding_median_filter assertion failed");
`else
`define SMF_ASSERT(lbl, prop)
`define SMF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/smf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

	localparam int WINDOW_LENGTH_DEF = 3;
	localparam int SAMPLE_WIDTH_DEF  = 16;

	// Status a cell shows to its neighbors.
	typedef struct packed {
		logic valid;     // cell holds a sample
		logic greater;   // held sample is above the incoming one (empty counts as above)
		logic evict_le;  // the evicted sample sits in this cell or below it
	} smf_link_t;

endpackage

`default_nettype wire

/* rtl/smf_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted window. Rebuilds its content from itself and its two
// neighbors: drop the evicted sample, insert the new one in order.
module smf_cell import smf_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
	localparam int AW = $clog2(WINDOW_LENGTH)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           full,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic signed [SAMPLE_WIDTH-1:0] lo_value,
	input  wire logic        [AW-1:0]           lo_age,
	input  wire smf_link_t                      lo_link,
	input  wire logic signed [SAMPLE_WIDTH-1:0] hi_value,
	input  wire logic        [AW-1:0]           hi_age,
	input  wire smf_link_t                      hi_link,
	output logic signed      [SAMPLE_WIDTH-1:0] value,
	output logic             [AW-1:0]           age,
	output smf_link_t                           link,
	output logic signed      [SAMPLE_WIDTH-1:0] next_value
);

	logic                           valid_q;
	logic signed [SAMPLE_WIDTH-1:0] value_q;
	logic        [AW-1:0]           age_q;

	logic                           evict;
	logic                           kg_own, kv_own, kg_lo, kv_lo;
	logic signed [SAMPLE_WIDTH-1:0] kval_own, kval_lo;
	logic        [AW-1:0]           kage_own, kage_lo;
	logic                           next_valid;
	logic        [AW-1:0]           next_age;

	assign evict         = full && valid_q && (age_q == AW'(WINDOW_LENGTH - 1));
	assign link.valid    = valid_q;
	assign link.greater  = !valid_q || (value_q > sample);
	assign link.evict_le = lo_link.evict_le | evict;
	assign value         = value_q;
	assign age           = age_q;

	// Survivor at this index once the evicted sample is taken out.
	always_comb begin
		if (link.evict_le) begin
			kg_own   = hi_link.greater;
			kv_own   = hi_link.valid;
			kval_own = hi_value;
			kage_own = hi_age;
		end else begin
			kg_own   = link.greater;
			kv_own   = valid_q;
			kval_own = value_q;
			kage_own = age_q;
		end
		if (lo_link.evict_le) begin
			kg_lo   = link.greater;
			kv_lo   = valid_q;
			kval_lo = value_q;
			kage_lo = age_q;
		end else begin
			kg_lo   = lo_link.greater;
			kv_lo   = lo_link.valid;
			kval_lo = lo_value;
			kage_lo = lo_age;
		end
	end

	// Keep the survivor, take the new sample, or shift the lower survivor up.
	always_comb begin
		priority if (!kg_own) begin
			next_value = kval_own;
			next_age   = kage_own + AW'(1);
			next_valid = kv_own;
		end else if (!kg_lo) begin
			next_value = sample;
			next_age   = '0;
			next_valid = 1'b1;
		end else begin
			next_value = kval_lo;
			next_age   = kage_lo + AW'(1);
			next_valid = kv_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= next_value;
			age_q   <= next_age;
		end
	end

endmodule

`default_nettype wire

/* rtl/sliding_median_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window median filter.
// Input channel: in_valid / in_ready carry one signed word, sample.
// Output channel: out_valid / out_ready carry one word per input word:
// filtered and window_full.
// The first WINDOW_LENGTH words after reset pass straight through with
// window_full low. From then on each word evicts the oldest one and the
// output is the element at index WINDOW_LENGTH/2 of the sorted window (the
// upper middle for an even length), with window_full high.
// A result is registered and shows on out_valid in the cycle after acceptance.
// Throughput: one word per cycle while the output is not stalled; the figure is
// set by the compare, evict and shift through the row of sorted cells, which all update together.
// Stall: a result waits in the output register; a new word is taken in the
// same cycle the waiting result leaves, so in_ready drops only while a result
// is held and out_ready is low.
// Reset (arst_n low): all cells empty, fill count zero, output register
// empty; the window starts filling with the first word after reset.
module sliding_median_filter import smf_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed      [SAMPLE_WIDTH-1:0] filtered,
	output logic                                window_full
);

`include "sliding_median_filter_macros.svh"

	localparam int AW  = $clog2(WINDOW_LENGTH);
	localparam int CW  = $clog2(WINDOW_LENGTH + 1);
	localparam int MID = WINDOW_LENGTH / 2;

	// Cell row plus one boundary slot at each end: index i+1 is cell i.
	logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_LENGTH+2];
	logic        [AW-1:0]           cell_age   [WINDOW_LENGTH+2];
	smf_link_t                      cell_link  [WINDOW_LENGTH+2];
	logic signed [SAMPLE_WIDTH-1:0] cell_next  [WINDOW_LENGTH];
	logic        [WINDOW_LENGTH-1:0] valid_vec;
	logic        [WINDOW_LENGTH-1:0] oldest_vec;

	logic [CW-1:0]                  count_q;
	logic                           full;
	logic                           accept;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] filtered_q;
	logic                           window_full_q;

	assign full     = (count_q == CW'(WINDOW_LENGTH));
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Below the row: never above the new word, nothing evicted.
	assign cell_value[0] = '0;
	assign cell_age[0]   = '0;
	assign cell_link[0]  = '{valid: 1'b0, greater: 1'b0, evict_le: 1'b0};
	// Above the row: acts as an empty slot.
	assign cell_value[WINDOW_LENGTH+1] = '0;
	assign cell_age[WINDOW_LENGTH+1]   = '0;
	assign cell_link[WINDOW_LENGTH+1]  = '{valid: 1'b0, greater: 1'b1, evict_le: 1'b0};

	for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
		smf_cell #(
			.WINDOW_LENGTH (WINDOW_LENGTH),
			.SAMPLE_WIDTH  (SAMPLE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (accept),
			.full       (full),
			.sample     (sample),
			.lo_value   (cell_value[i]),
			.lo_age     (cell_age[i]),
			.lo_link    (cell_link[i]),
			.hi_value   (cell_value[i+2]),
			.hi_age     (cell_age[i+2]),
			.hi_link    (cell_link[i+2]),
			.value      (cell_value[i+1]),
			.age        (cell_age[i+1]),
			.link       (cell_link[i+1]),
			.next_value (cell_next[i])
		);
		assign valid_vec[i]  = cell_link[i+1].valid;
		assign oldest_vec[i] = cell_link[i+1].valid
			&& (cell_age[i+1] == AW'(WINDOW_LENGTH - 1));
	end

	// Fill count: advance until the window is full, then hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Output register: load on accept, drop once the receiver takes the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			filtered_q    <= full ? cell_next[MID] : sample;
			window_full_q <= full;
		end
	end

	assign out_valid   = out_valid_q;
	assign filtered    = filtered_q;
	assign window_full = window_full_q;

	// The fill count never runs past the window length.
	`SMF_ASSERT(a_count_range, count_q <= CW'(WINDOW_LENGTH))
	// Occupied cells always match the fill count.
	`SMF_ASSERT(a_valid_count, $countones(valid_vec) == int'(count_q))
	// A full window has exactly one sample ready for eviction.
	`SMF_ASSERT(a_one_oldest, full |-> $onehot(oldest_vec))
	// A new result appears only after a word was taken in.
	`SMF_ASSERT(a_out_from_accept, $rose(out_valid_q) |-> $past(accept))

endmodule

`default_nettype wire
